@@ hw/rtl/pet_pkg.sv @@
package pet_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VERTEX_W     = 6;
    localparam int COUNT_W      = 7;
    localparam int TABLE_DEPTH  = (MAX_VERTICES * (MAX_VERTICES - 1)) / 2;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int LEN_W        = 16;
    localparam int PHER_W       = 32;
    localparam int RATE_W       = 16;
    localparam int FACTOR_W     = RATE_W + 1;
    localparam int HI_W         = PHER_W - 16;
    localparam int PROD_W       = 16 + FACTOR_W;
    localparam int TOTAL_W      = 11;
    localparam int SUM_W        = 27;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic [COUNT_W-1:0]  VERTEX_COUNT_RESET = COUNT_W'(64);
    localparam logic [PHER_W-1:0]   MIN_PHER_RESET     = PHER_W'(65536);
    localparam logic [RATE_W-1:0]   RATE_RESET         = RATE_W'(6554);
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX          = '1;
    localparam logic [SUM_W-1:0]    SUM_MAX            = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PHEROMONE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_EVAP_RATE     = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        OP_CONNECT   = 3'd0,
        OP_SELECT    = 3'd1,
        OP_ADD       = 3'd2,
        OP_QUERY     = 3'd3,
        OP_EVAPORATE = 3'd4,
        OP_CLEAR     = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_SELF_LOOP = 2'd1,
        STS_RANGE     = 2'd2,
        STS_ABSENT    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_SW_RD,
        S_SW_MUL,
        S_SW_WR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              sel;
        logic [PHER_W-1:0] pher;
        logic [LEN_W-1:0]  len;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic init_wr;
        logic sweep_mul;
        logic sweep_wr;
        logic out_load;
        logic use_cnt;
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/pheromone_edge_table.sv @@
// Pheromone edge table for an undirected graph of up to 64 vertices, one
// 50-bit entry per vertex pair in a single-port memory of 2016 words. After
// reset the table clears every entry in turn and takes no item meanwhile
// (configuration writes are taken). Connect, set selected, add pheromone and
// query pass through address, memory read, read-modify-write and result
// transfer. Evaporate and clear walk every entry through the memory port in
// read, multiply and write states; a new item waits until the last result is
// loaded. The next item is taken while a result still waits on the output.
module pheromone_edge_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pet_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pet_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        op,
    input  logic [pet_pkg::VERTEX_W-1:0]      vertex_a,
    input  logic [pet_pkg::VERTEX_W-1:0]      vertex_b,
    input  logic [pet_pkg::LEN_W-1:0]         edge_length,
    input  logic                              selected_flag,
    input  logic [pet_pkg::PHER_W-1:0]        pheromone_amount,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic                              edge_present,
    output logic [pet_pkg::LEN_W-1:0]         length_out,
    output logic [pet_pkg::PHER_W-1:0]        pheromone_out,
    output logic                              selected_out,
    output logic [pet_pkg::TOTAL_W-1:0]       edge_total,
    output logic [pet_pkg::SUM_W-1:0]         length_total
);
    import pet_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    pet_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .op               (op),
        .vertex_a         (vertex_a),
        .vertex_b         (vertex_b),
        .edge_length      (edge_length),
        .selected_flag    (selected_flag),
        .pheromone_amount (pheromone_amount),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .edge_present     (edge_present),
        .length_out       (length_out),
        .pheromone_out    (pheromone_out),
        .selected_out     (selected_out),
        .edge_total       (edge_total),
        .length_total     (length_total)
    );

endmodule

@@ hw/rtl/pet_ctrl.sv @@
module pet_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [2:0]    op,
    input  pet_pkg::sts_t sts,
    output logic          in_stall,
    output pet_pkg::cmd_t cmd
);
    import pet_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                cmd.use_cnt = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (op_t'(op))
                        OP_CONNECT, OP_SELECT, OP_ADD, OP_QUERY: state_next = S_LOOKUP;
                        OP_EVAPORATE, OP_CLEAR:                  state_next = S_SW_RD;
                        default:                                 state_next = S_RESULT;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESULT;
            end
            S_SW_RD:
            begin
                cmd.use_cnt = 1'b1;
                state_next  = S_SW_MUL;
            end
            S_SW_MUL:
            begin
                cmd.use_cnt   = 1'b1;
                cmd.sweep_mul = 1'b1;
                state_next    = S_SW_WR;
            end
            S_SW_WR:
            begin
                cmd.use_cnt  = 1'b1;
                cmd.sweep_wr = 1'b1;
                state_next   = sts.cnt_last ? S_RESULT : S_SW_RD;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/pet_dp.sv @@
module pet_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pet_pkg::cmd_t                     cmd,
    output pet_pkg::sts_t                     sts,
    input  logic                              cfg_we,
    input  logic [pet_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pet_pkg::CFG_W-1:0]         cfg_data,
    input  logic [2:0]                        op,
    input  logic [pet_pkg::VERTEX_W-1:0]      vertex_a,
    input  logic [pet_pkg::VERTEX_W-1:0]      vertex_b,
    input  logic [pet_pkg::LEN_W-1:0]         edge_length,
    input  logic                              selected_flag,
    input  logic [pet_pkg::PHER_W-1:0]        pheromone_amount,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic                              edge_present,
    output logic [pet_pkg::LEN_W-1:0]         length_out,
    output logic [pet_pkg::PHER_W-1:0]        pheromone_out,
    output logic                              selected_out,
    output logic [pet_pkg::TOTAL_W-1:0]       edge_total,
    output logic [pet_pkg::SUM_W-1:0]         length_total
);
    import pet_pkg::*;

    entry_t mem [TABLE_DEPTH];

    logic [COUNT_W-1:0]  vc_reg;
    logic [PHER_W-1:0]   min_reg;
    logic [RATE_W-1:0]   rate_reg;

    op_t                 op_reg;
    logic [LEN_W-1:0]    len_in_reg;
    logic                sel_in_reg;
    logic [PHER_W-1:0]   amt_reg;
    status_t             err_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic [IDX_W-1:0]    cnt_reg;
    entry_t              rd_data_reg;
    logic [PROD_W-1:0]   prod_hi_reg;
    logic [PROD_W-1:0]   prod_lo_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [SUM_W-1:0]    sum_reg;

    status_t             res_status_reg;
    logic                res_present_reg;
    entry_t              res_entry_reg;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic                out_present_reg;
    entry_t              out_entry_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic [SUM_W-1:0]    out_sum_reg;

    logic [COUNT_W-1:0]    limit;
    logic [VERTEX_W-1:0]   vm;
    logic [VERTEX_W-1:0]   vn;
    logic [2*VERTEX_W-1:0] tri_prod;
    logic [IDX_W-1:0]      idx;
    status_t               err;

    logic [IDX_W-1:0]    mem_addr;
    logic                mem_we;
    entry_t              mem_wdata;

    status_t             exec_sts;
    logic                exec_wr;
    entry_t              exec_entry;
    logic [PHER_W:0]     pher_sum;
    logic [SUM_W:0]      len_sum;
    logic [FACTOR_W-1:0] factor;
    logic [PHER_W-1:0]   scaled;

    // Triangular address and argument checks on the incoming item
    always_comb
    begin
        limit    = (vc_reg > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES) : vc_reg;
        vm       = (vertex_a > vertex_b) ? vertex_a : vertex_b;
        vn       = (vertex_a > vertex_b) ? vertex_b : vertex_a;
        tri_prod = (2*VERTEX_W)'(vm) * (2*VERTEX_W)'(vm - VERTEX_W'(1));
        idx      = IDX_W'(tri_prod >> 1) + IDX_W'(vn);
        priority if (COUNT_W'(vertex_a) >= limit || COUNT_W'(vertex_b) >= limit)
            err = STS_RANGE;
        else if (vertex_a == vertex_b)
            err = STS_SELF_LOOP;
        else
            err = STS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg   <= VERTEX_COUNT_RESET;
            min_reg  <= MIN_PHER_RESET;
            rate_reg <= RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT:  vc_reg   <= cfg_data[COUNT_W-1:0];
                CFG_MIN_PHEROMONE: min_reg  <= cfg_data[PHER_W-1:0];
                CFG_EVAP_RATE:     rate_reg <= cfg_data[RATE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op_t'(op);
            len_in_reg <= edge_length;
            sel_in_reg <= selected_flag;
            amt_reg    <= pheromone_amount;
            err_reg    <= err;
            addr_reg   <= idx;
        end
    end

    assign mem_addr = cmd.use_cnt ? cnt_reg : addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.capture)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.init_wr || cmd.sweep_wr)
        begin
            cnt_reg <= cnt_reg + IDX_W'(1);
        end
    end

    assign sts.cnt_last = (cnt_reg == IDX_W'(TABLE_DEPTH - 1));
    assign sts.out_free = !out_valid_reg || !out_stall;

    // Evaporation scaling, split as high and low halves
    assign factor = FACTOR_W'(1 << RATE_W) - FACTOR_W'(rate_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_mul)
        begin
            prod_hi_reg <= PROD_W'(rd_data_reg.pher[PHER_W-1:16]) * PROD_W'(factor);
            prod_lo_reg <= PROD_W'(rd_data_reg.pher[15:0]) * PROD_W'(factor);
        end
    end

    assign scaled = PHER_W'(prod_hi_reg + (prod_lo_reg >> 16));

    always_comb
    begin
        exec_sts   = err_reg;
        exec_wr    = 1'b0;
        exec_entry = rd_data_reg;
        pher_sum   = {1'b0, rd_data_reg.pher} + {1'b0, amt_reg};
        len_sum    = {1'b0, sum_reg} + (SUM_W + 1)'(len_in_reg);
        if (err_reg == STS_OK)
        begin
            priority if (op_reg == OP_CONNECT)
            begin
                exec_wr    = 1'b1;
                exec_entry = '{valid: 1'b1, sel: 1'b0, pher: min_reg, len: len_in_reg};
            end
            else if (!rd_data_reg.valid)
            begin
                exec_sts = STS_ABSENT;
            end
            else if (op_reg == OP_SELECT)
            begin
                exec_wr        = 1'b1;
                exec_entry.sel = sel_in_reg;
            end
            else if (op_reg == OP_ADD)
            begin
                exec_wr         = 1'b1;
                exec_entry.pher = pher_sum[PHER_W] ? '1 : pher_sum[PHER_W-1:0];
            end
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = rd_data_reg;
        priority if (cmd.init_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = '0;
        end
        else if (cmd.sweep_wr)
        begin
            if (op_reg == OP_EVAPORATE)
            begin
                if (rd_data_reg.valid && rd_data_reg.pher >= min_reg)
                begin
                    mem_we         = 1'b1;
                    mem_wdata.pher = scaled;
                end
            end
            else if (rd_data_reg.valid)
            begin
                mem_we         = 1'b1;
                mem_wdata.sel  = 1'b0;
                mem_wdata.pher = '0;
            end
        end
        else if (cmd.exec)
        begin
            mem_we    = exec_wr;
            mem_wdata = exec_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.exec && err_reg == STS_OK && op_reg == OP_CONNECT)
        begin
            if (!rd_data_reg.valid && total_reg != TOTAL_MAX)
            begin
                total_reg <= total_reg + TOTAL_W'(1);
            end
            sum_reg <= len_sum[SUM_W] ? SUM_MAX : len_sum[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_status_reg  <= STS_OK;
            res_present_reg <= 1'b0;
            res_entry_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            res_status_reg  <= exec_sts;
            res_present_reg <= (exec_sts == STS_OK);
            res_entry_reg   <= (exec_sts == STS_OK) ? exec_entry : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_present_reg <= res_present_reg;
            out_entry_reg   <= res_entry_reg;
            out_total_reg   <= total_reg;
            out_sum_reg     <= sum_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign edge_present  = out_present_reg;
    assign length_out    = out_entry_reg.len;
    assign pheromone_out = out_entry_reg.pher;
    assign selected_out  = out_entry_reg.sel;
    assign edge_total    = out_total_reg;
    assign length_total  = out_sum_reg;

endmodule

@@ sim/pheromone_edge_table_tb.sv @@
`timescale 1ns / 100ps

module pheromone_edge_table_tb;
    import pet_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEMS_PER_PHASE = 310;

    typedef struct {
        status_t           st;
        logic              present;
        logic [LEN_W-1:0]  len;
        logic [PHER_W-1:0] pher;
        logic              sel;
        logic [TOTAL_W-1:0] total;
        logic [SUM_W-1:0]  sum;
    } reply_t;

    class edge_table_model;
        bit                 valid_q [TABLE_DEPTH];
        logic [LEN_W-1:0]   len_q   [TABLE_DEPTH];
        logic [PHER_W-1:0]  pher_q  [TABLE_DEPTH];
        bit                 sel_q   [TABLE_DEPTH];
        int unsigned        edge_cnt;
        int unsigned        len_sum;
        int unsigned        vcount;
        logic [PHER_W-1:0]  min_pher;
        logic [RATE_W-1:0]  rate;
        reply_t             replies [$];
        int                 errors;
        int                 checked;

        function new();
            foreach (valid_q[i]) valid_q[i] = 0;
            edge_cnt = 0;
            len_sum  = 0;
            vcount   = 64;
            min_pher = 32'h0001_0000;
            rate     = 16'd6554;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_VERTEX_COUNT)
                vcount = data[COUNT_W-1:0];
            else if (idx == CFG_MIN_PHEROMONE)
                min_pher = data[PHER_W-1:0];
            else if (idx == CFG_EVAP_RATE)
                rate = data[RATE_W-1:0];
        endfunction

        function logic [PHER_W-1:0] evaporated(logic [PHER_W-1:0] p);
            logic [63:0] f;
            logic [63:0] hi;
            logic [63:0] lo;
            f  = 64'd65536 - 64'(rate);
            hi = 64'(p >> 16);
            lo = 64'(p[15:0]);
            return PHER_W'(hi * f + ((lo * f) >> 16));
        endfunction

        function void note_item(logic [2:0] code, logic [5:0] a, logic [5:0] b,
                                logic [LEN_W-1:0] l, logic s, logic [PHER_W-1:0] amt);
            reply_t r;
            int unsigned lim;
            int unsigned m;
            int unsigned n;
            int unsigned idx;
            logic [32:0] psum;
            r.st = STS_OK;
            r.present = 0;
            r.len = '0;
            r.pher = '0;
            r.sel = 0;
            lim = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
            if (code <= OP_QUERY) begin
                if (a >= lim || b >= lim)
                    r.st = STS_RANGE;
                else if (a == b)
                    r.st = STS_SELF_LOOP;
                else begin
                    m = (a > b) ? a : b;
                    n = (a > b) ? b : a;
                    idx = (m * (m - 1)) / 2 + n;
                    if (code == OP_CONNECT) begin
                        if (!valid_q[idx] && edge_cnt < 2047)
                            edge_cnt++;
                        valid_q[idx] = 1;
                        len_q[idx] = l;
                        pher_q[idx] = min_pher;
                        sel_q[idx] = 0;
                        len_sum = len_sum + l;
                        if (len_sum > 134217727)
                            len_sum = 134217727;
                    end else if (!valid_q[idx])
                        r.st = STS_ABSENT;
                    else if (code == OP_SELECT)
                        sel_q[idx] = s;
                    else if (code == OP_ADD) begin
                        psum = 33'(pher_q[idx]) + 33'(amt);
                        pher_q[idx] = psum[32] ? '1 : psum[31:0];
                    end
                    if (r.st == STS_OK) begin
                        r.present = 1;
                        r.len = len_q[idx];
                        r.pher = pher_q[idx];
                        r.sel = sel_q[idx];
                    end
                end
            end else if (code == OP_EVAPORATE) begin
                foreach (valid_q[i])
                    if (valid_q[i] && pher_q[i] >= min_pher)
                        pher_q[i] = evaporated(pher_q[i]);
            end else if (code == OP_CLEAR) begin
                foreach (valid_q[i])
                    if (valid_q[i]) begin
                        sel_q[i] = 0;
                        pher_q[i] = '0;
                    end
            end
            r.total = TOTAL_W'(edge_cnt);
            r.sum = SUM_W'(len_sum);
            replies.push_back(r);
        endfunction

        function void field_cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_reply(reply_t act);
            reply_t e;
            if (replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got status %0d",
                         $time, act.st);
                return;
            end
            e = replies.pop_front();
            checked++;
            field_cmp("status", 64'(e.st), 64'(act.st));
            field_cmp("edge_present", 64'(e.present), 64'(act.present));
            field_cmp("length_out", 64'(e.len), 64'(act.len));
            field_cmp("pheromone_out", 64'(e.pher), 64'(act.pher));
            field_cmp("selected_out", 64'(e.sel), 64'(act.sel));
            field_cmp("edge_total", 64'(e.total), 64'(act.total));
            field_cmp("length_total", 64'(e.sum), 64'(act.sum));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [2:0]           op;
    logic [VERTEX_W-1:0]  vertex_a;
    logic [VERTEX_W-1:0]  vertex_b;
    logic [LEN_W-1:0]     edge_length;
    logic                 selected_flag;
    logic [PHER_W-1:0]    pheromone_amount;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           status;
    logic                 edge_present;
    logic [LEN_W-1:0]     length_out;
    logic [PHER_W-1:0]    pheromone_out;
    logic                 selected_out;
    logic [TOTAL_W-1:0]   edge_total;
    logic [SUM_W-1:0]     length_total;

    edge_table_model sb;
    bit hold_req;
    int items_sent;
    int sweeps_sent;
    int burst_left;
    int idle_cycles;

    pheromone_edge_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .vertex_a(vertex_a), .vertex_b(vertex_b),
        .edge_length(edge_length), .selected_flag(selected_flag),
        .pheromone_amount(pheromone_amount),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .edge_present(edge_present), .length_out(length_out),
        .pheromone_out(pheromone_out), .selected_out(selected_out),
        .edge_total(edge_total), .length_total(length_total)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // check each result transfer
    always @(posedge clk)
    begin
        reply_t act;
        if (rst_n && out_valid && !out_stall)
        begin
            act.st = status_t'(status);
            act.present = edge_present;
            act.len = length_out;
            act.pher = pheromone_out;
            act.sel = selected_out;
            act.total = edge_total;
            act.sum = length_total;
            sb.check_reply(act);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern
    initial
    begin
        int mode;
        int run;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            mode = $urandom_range(0, 3);
            run = $urandom_range(1, 40);
            repeat (run)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_item(logic [2:0] code, logic [5:0] a, logic [5:0] b,
                             logic [LEN_W-1:0] l, logic s, logic [PHER_W-1:0] amt);
        op <= code;
        vertex_a <= a;
        vertex_b <= b;
        edge_length <= l;
        selected_flag <= s;
        pheromone_amount <= amt;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && !in_stall));
        sb.note_item(code, a, b, l, s, amt);
        items_sent++;
        if (code == OP_EVAPORATE || code == OP_CLEAR)
            sweeps_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.replies.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_config(int unsigned vc, logic [31:0] mp, logic [15:0] rt);
        write_reg(CFG_VERTEX_COUNT, CFG_W'(vc));
        write_reg(CFG_MIN_PHEROMONE, mp);
        write_reg(CFG_EVAP_RATE, CFG_W'(rt));
        cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        int unsigned r;
        int unsigned lim;
        int unsigned pool;
        logic [2:0] code;
        logic [5:0] a;
        logic [5:0] b;
        logic [LEN_W-1:0] l;
        logic [PHER_W-1:0] amt;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        r = $urandom_range(0, 199);
        if (r < 60) code = OP_CONNECT;
        else if (r < 90) code = OP_SELECT;
        else if (r < 130) code = OP_ADD;
        else if (r < 186) code = OP_QUERY;
        else if (r < 189) code = OP_EVAPORATE;
        else if (r < 191) code = OP_CLEAR;
        else code = 3'($urandom_range(6, 7));
        lim = (sb.vcount > MAX_VERTICES) ? MAX_VERTICES : sb.vcount;
        pool = (lim > 8) ? 8 : lim;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            a = 6'($urandom_range(0, pool - 1));
            b = 6'($urandom_range(0, pool - 1));
        end
        else if (r < 80)
        begin
            a = 6'($urandom);
            b = 6'($urandom);
        end
        else if (r < 88)
        begin
            a = 6'($urandom_range(0, lim - 1));
            b = a;
        end
        else
        begin
            a = 6'($urandom_range(0, lim - 1));
            b = 6'($urandom_range(0, lim - 1));
        end
        r = $urandom_range(0, 9);
        l = (r < 2) ? '1 : (r < 3) ? '0 : LEN_W'($urandom);
        r = $urandom_range(0, 3);
        amt = (r == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 255) :
              (r == 1) ? $urandom_range(0, 32'h0003_0000) : $urandom;
        send_item(code, a, b, l, 1'($urandom), amt);
    endtask

    initial
    begin
        int unsigned vc_set [6];
        logic [31:0] mp_set [6];
        logic [15:0] rt_set [6];
        vc_set = '{64, 2, 64, 8, 127, 5};
        mp_set = '{32'h0001_0000, 32'h0, 32'hFFFF_FFFF,
                   32'h0000_8000, 32'h1, 32'h0002_0000};
        rt_set = '{16'd6554, 16'hFFFF, 16'h0, 16'h8000, 16'h1, 16'hFFFF};
        sb = new();
        hold_req = 0;
        items_sent = 0;
        sweeps_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = '0;
        vertex_a = '0;
        vertex_b = '0;
        edge_length = '0;
        selected_flag = 1'b0;
        pheromone_amount = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(10, 32'h0001_0000, 16'd6554);
        send_item(OP_CONNECT, 1, 2, 16'hFFFF, 1, 32'h0);
        send_item(OP_CONNECT, 3, 0, 16'h0, 0, 32'h0);
        send_item(OP_QUERY, 2, 1, 16'h0, 0, 32'h0);
        send_item(OP_QUERY, 0, 3, 16'h0, 0, 32'h0);
        send_item(OP_QUERY, 4, 5, 16'h0, 0, 32'h0);
        send_item(OP_CONNECT, 5, 5, 16'h1234, 0, 32'h0);
        send_item(OP_CONNECT, 10, 1, 16'h1234, 0, 32'h0);
        send_item(OP_QUERY, 63, 63, 16'h0, 0, 32'h0);
        send_item(OP_SELECT, 1, 2, 16'h0, 1, 32'h0);
        send_item(OP_SELECT, 4, 6, 16'h0, 1, 32'h0);
        send_item(OP_ADD, 2, 1, 16'h0, 0, 32'hFFFF_FFFF);
        send_item(OP_ADD, 0, 3, 16'h0, 0, 32'h0);
        send_item(OP_ADD, 9, 9, 16'h0, 0, 32'h5);
        send_item(OP_EVAPORATE, 0, 0, 16'h0, 0, 32'h0);
        send_item(OP_QUERY, 1, 2, 16'h0, 0, 32'h0);
        send_item(OP_QUERY, 3, 0, 16'h0, 0, 32'h0);
        send_item(OP_CLEAR, 0, 0, 16'h0, 0, 32'h0);
        send_item(3'd6, 1, 2, 16'hFFFF, 1, 32'hFFFF_FFFF);
        send_item(3'd7, 63, 0, 16'h0, 0, 32'h0);
        send_item(OP_QUERY, 1, 2, 16'h0, 0, 32'h0);
        send_item(OP_CONNECT, 2, 1, 16'd7, 0, 32'h0);
        send_item(OP_QUERY, 9, 8, 16'h0, 0, 32'h0);
        send_item(OP_ADD, 9, 8, 16'h0, 0, 32'h1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            set_config(vc_set[ph], mp_set[ph], rt_set[ph]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // hold the receiver off while the sender keeps offering
                if (ph == 1 && k == 100)
                    hold_req = 1;
                if (ph == 2 && k == 150)
                    drain();
                random_item();
            end
            drain();
        end

        repeat (40) @(posedge clk);
        $display("sent %0d items (%0d table sweeps), checked %0d results",
                 items_sent, sweeps_sent, sb.checked);
        $display("covered six register settings incl. extremes, long output hold-off");
        if (sb.errors == 0 && sb.replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
